/* rtl/top_k_sorted_insert_table_unit_macros.svh */
// Assertion helpers shared by the RTL of the top-k table.
`ifndef TOP_K_SORTED_INSERT_TABLE_UNIT_MACROS_SVH
`define TOP_K_SORTED_INSERT_TABLE_UNIT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define TKSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define TKSI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TKSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tksi_pkg.sv */
package tksi_pkg;

  // input beat
  typedef struct packed {
    logic signed [31:0] new_score;
    logic        [15:0] new_level;
  } in_t;

  // output beat: one table row
  typedef struct packed {
    logic        [5:0]  rank;
    logic signed [31:0] entry_score;
    logic        [15:0] entry_level;
    logic        [6:0]  entry_count;
    logic               last;
  } out_t;

  // one memory word
  typedef struct packed {
    logic signed [31:0] score;
    logic        [15:0] level;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_WRBACK,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_e;

endpackage

/* rtl/top_k_sorted_insert_table_unit.sv */
// Top-k table: one beat in, the whole sorted table (entry_count beats) out.
// An input beat is taken only in idle; the block then scans the table,
// carrying the new row down (a full table first compares the offer with the
// tail), writes the carry back, and dumps every row through the output
// register, where the dump stalls while out_ready_i is low. Scan and dump
// share one read and one write port. Reset (async): table empty, FSM idle.
`include "top_k_sorted_insert_table_unit_macros.svh"

module top_k_sorted_insert_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tksi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tksi_pkg::out_t out_data_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  tksi_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q;    // valid rows
  logic [AW-1:0]    lastpos_q;  // count - 1 after the insert
  logic [AW-1:0]    idx_q;      // scan / dump position
  tksi_pkg::entry_t carry_q;    // entry carried down the scan
  tksi_pkg::entry_t new_q;      // offered entry (full-table compare)
  tksi_pkg::entry_t rdata_q;    // registered memory read data
  tksi_pkg::out_t   out_q;
  logic             out_valid_q;

  // row storage, one write and one read port
  tksi_pkg::entry_t mem_q [TABLE_DEPTH];

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  logic             in_fire;
  logic             full;
  logic             swap;
  logic             out_load;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  tksi_pkg::entry_t in_entry;

  assign in_entry.score = in_data_i.new_score;
  assign in_entry.level = in_data_i.new_level;
  assign full           = (count_q == CW'(TABLE_DEPTH));
  assign in_fire        = in_valid_i && in_ready_o;
  // stored row loses to the carry only on a strictly lower score
  assign swap           = (rdata_q.score < carry_q.score);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tksi_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (full) begin
            state_d = tksi_pkg::ST_CHK;
          end else if (count_q == '0) begin
            state_d = tksi_pkg::ST_WRBACK;  // single row, nothing to scan
          end else begin
            state_d = tksi_pkg::ST_SCAN;
          end
        end
      end
      tksi_pkg::ST_CHK:     state_d = tksi_pkg::ST_SCAN;
      tksi_pkg::ST_SCAN: begin
        if (idx_q == lastpos_q - AW'(1)) begin
          state_d = tksi_pkg::ST_WRBACK;
        end
      end
      tksi_pkg::ST_WRBACK:  state_d = tksi_pkg::ST_DUMP_RD;
      tksi_pkg::ST_DUMP_RD: state_d = tksi_pkg::ST_DUMP_LD;
      tksi_pkg::ST_DUMP_LD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = (idx_q == lastpos_q) ? tksi_pkg::ST_IDLE : tksi_pkg::ST_DUMP_RD;
        end
      end
      default:              state_d = tksi_pkg::ST_IDLE;
    endcase
  end

  // outputs of the FSM: memory port controls and handshakes
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    out_load   = 1'b0;
    case (state_q)
      tksi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        // full: fetch the tail for the compare; else prefetch row 0
        mem_re     = in_valid_i;
        mem_raddr  = full ? AW'(TABLE_DEPTH - 1) : '0;
      end
      tksi_pkg::ST_CHK: begin
        mem_re = 1'b1;  // prefetch row 0
      end
      tksi_pkg::ST_SCAN: begin
        // row idx is in rdata_q; fetch idx+1 while writing idx
        mem_re    = 1'b1;
        mem_raddr = idx_q + AW'(1);
        mem_we    = swap;
        mem_waddr = idx_q;
      end
      tksi_pkg::ST_WRBACK: begin
        mem_we    = 1'b1;
        mem_waddr = lastpos_q;
      end
      tksi_pkg::ST_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
      end
      tksi_pkg::ST_DUMP_LD: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Memory: written with the carry only
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= carry_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tksi_pkg::ST_IDLE;
      count_q   <= '0;
      lastpos_q <= '0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        tksi_pkg::ST_IDLE: begin
          if (in_fire) begin
            idx_q <= '0;
            if (full) begin
              lastpos_q <= AW'(TABLE_DEPTH - 1);
            end else begin
              lastpos_q <= count_q[AW-1:0];
              count_q   <= count_q + CW'(1);
            end
          end
        end
        tksi_pkg::ST_SCAN:    idx_q <= idx_q + AW'(1);
        tksi_pkg::ST_WRBACK:  idx_q <= '0;
        tksi_pkg::ST_DUMP_LD: begin
          if (out_load) begin
            idx_q <= idx_q + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // carry and offered entry (payload, no reset)
  always_ff @(posedge clk_i) begin
    case (state_q)
      tksi_pkg::ST_IDLE: begin
        if (in_fire) begin
          new_q   <= in_entry;
          carry_q <= in_entry;  // append case: new row is the carry
        end
      end
      tksi_pkg::ST_CHK: begin
        // full table: the offer replaces the tail only on a strictly higher score
        carry_q <= (rdata_q.score < new_q.score) ? new_q : rdata_q;
      end
      tksi_pkg::ST_SCAN: begin
        if (swap) begin
          carry_q <= rdata_q;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register: the input side reopens while the last beat waits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.rank        <= 6'(idx_q);
      out_q.entry_score <= rdata_q.score;
      out_q.entry_level <= rdata_q.level;
      out_q.entry_count <= 7'(count_q);
      out_q.last        <= (idx_q == lastpos_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TKSI_ASSERT(a_count_range, count_q <= CW'(TABLE_DEPTH), "row count above table depth")
  `TKSI_ASSERT_IMPL(a_port_split, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one row")
  `TKSI_ASSERT_IMPL(a_no_overwrite, out_load, !out_valid_q || out_ready_i, "output beat overwritten")
  `TKSI_ASSERT_NEXT(a_count_nonzero, in_fire, count_q != '0, "table empty after an insert")
  `TKSI_ASSERT_IMPL(a_last_rank, out_valid_o && out_data_o.last, {1'b0, out_data_o.rank} == out_data_o.entry_count - 7'd1, "last beat not at the final rank")

endmodule
